[rtl/core/ple_pkg.sv]
// Shared types and constants for the pneumatic launcher position estimator.
`timescale 1ns / 1ps

package ple_pkg;

    localparam int unsigned TICK_W = 16;

    localparam logic [TICK_W-1:0] RISE_TICKS_RST      = 16'd25;
    localparam logic [TICK_W-1:0] MIN_LOWER_TICKS_RST = 16'd21;
    localparam logic [TICK_W-1:0] MAX_LOWER_TICKS_RST = 16'd100;
    localparam logic [TICK_W-1:0] VENT_TICKS_RST      = 16'd25;

    // Piston location estimate
    typedef enum logic [2:0] {
        LOC_GOING_UP   = 3'd0,
        LOC_UP         = 3'd1,
        LOC_GOING_DOWN = 3'd2,
        LOC_DOWN_VENT  = 3'd3,
        LOC_DOWN_IDLE  = 3'd4,
        LOC_UNKNOWN    = 3'd5
    } loc_t;

    // Valve command; code three acts as vent
    typedef enum logic [1:0] {
        DRV_UP   = 2'd0,
        DRV_DOWN = 2'd1,
        DRV_VENT = 2'd2
    } drive_t;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_SHOOTING = 2'd1,
        ST_RECOVERY = 2'd2
    } status_t;

    // Operator goal; code three acts as wait
    typedef enum logic [1:0] {
        GOAL_START = 2'd0,
        GOAL_WAIT  = 2'd1,
        GOAL_ANY   = 2'd2
    } goal_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_RISE_TICKS      = 2'd0,
        REG_MIN_LOWER_TICKS = 2'd1,
        REG_MAX_LOWER_TICKS = 2'd2,
        REG_VENT_TICKS      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] rise_ticks;
        logic [TICK_W-1:0] min_lower_ticks;
        logic [TICK_W-1:0] max_lower_ticks;
        logic [TICK_W-1:0] vent_ticks;
    } thresholds_t;

    // Outcome of one tick: new state plus the reported fields
    typedef struct packed {
        logic [2:0]        location;
        logic [TICK_W-1:0] elapsed;
        logic [1:0]        status;
        logic              ready_flag;
        logic [1:0]        next_drive;
    } step_res_t;

endpackage

[rtl/core/pneumatic_launcher_position_estimator.sv]
// Top level of the pneumatic launcher position estimator.
`timescale 1ns / 1ps

// One beat in per control tick, one result beat out per tick. A beat is taken
// into an input register; once the result register is empty or draining, the
// transition rule runs from it against the location and tick-counter
// registers, updating them and loading the result register. Throughput is one
// beat per cycle while m_ready holds, the result draining as the next is taken.
// Thresholds are written by the user through the cfg port (index 0 rise, 1 min
// lower, 2 max lower, 3 vent) only while no beat is in flight; not enforced.

module pneumatic_launcher_position_estimator (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [ple_pkg::TICK_W-1:0] cfg_data,
    // input ticks
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_applied_drive,
    input  logic                       s_down_sensor,
    input  logic [1:0]                 s_goal,
    // results
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_location,
    output logic [1:0]                 m_status,
    output logic                       m_ready_flag,
    output logic [1:0]                 m_next_drive
);

    ple_pkg::thresholds_t       thr_reg;
    logic                       in_valid_reg;
    logic [1:0]                 in_drive_reg;
    logic                       in_sensor_reg;
    logic [1:0]                 in_goal_reg;
    logic [2:0]                 loc_reg;
    logic [ple_pkg::TICK_W-1:0] elapsed_reg;
    logic                       out_valid_reg;
    ple_pkg::step_res_t         out_reg;
    ple_pkg::step_res_t         res;
    logic                       out_load;

    assign cfg_ready = 1'b1;

    // Threshold registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg.rise_ticks      <= ple_pkg::RISE_TICKS_RST;
            thr_reg.min_lower_ticks <= ple_pkg::MIN_LOWER_TICKS_RST;
            thr_reg.max_lower_ticks <= ple_pkg::MAX_LOWER_TICKS_RST;
            thr_reg.vent_ticks      <= ple_pkg::VENT_TICKS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ple_pkg::REG_RISE_TICKS:      thr_reg.rise_ticks      <= cfg_data;
                ple_pkg::REG_MIN_LOWER_TICKS: thr_reg.min_lower_ticks <= cfg_data;
                ple_pkg::REG_MAX_LOWER_TICKS: thr_reg.max_lower_ticks <= cfg_data;
                ple_pkg::REG_VENT_TICKS:      thr_reg.vent_ticks      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Flow control: result register loads when empty or being drained
    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_drive_reg  <= s_applied_drive;
            in_sensor_reg <= s_down_sensor;
            in_goal_reg   <= s_goal;
        end
    end

    ple_step u_step (
        .applied_drive (in_drive_reg),
        .down_sensor   (in_sensor_reg),
        .goal          (in_goal_reg),
        .location      (loc_reg),
        .elapsed       (elapsed_reg),
        .thr           (thr_reg),
        .res           (res)
    );

    // Estimator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loc_reg     <= ple_pkg::LOC_GOING_DOWN;
            elapsed_reg <= '0;
        end else if (out_load) begin
            loc_reg     <= res.location;
            elapsed_reg <= res.elapsed;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_location   = out_reg.location;
    assign m_status     = out_reg.status;
    assign m_ready_flag = out_reg.ready_flag;
    assign m_next_drive = out_reg.next_drive;

endmodule

[rtl/core/ple_step.sv]
// Transition rule for one control tick: counter advance, location update, outputs.
`timescale 1ns / 1ps

module ple_step (
    input  logic [1:0]                 applied_drive,
    input  logic                       down_sensor,
    input  logic [1:0]                 goal,
    input  logic [2:0]                 location,
    input  logic [ple_pkg::TICK_W-1:0] elapsed,
    input  ple_pkg::thresholds_t       thr,
    output ple_pkg::step_res_t         res
);

    logic [ple_pkg::TICK_W-1:0] t;
    logic [2:0]                 loc_nxt;
    logic                       clr;
    logic                       gt_rise;
    logic                       gt_min;
    logic                       gt_max;
    logic                       gt_vent;
    logic [1:0]                 st;

    // Saturating advance, then the four strict compares
    assign t       = (elapsed == '1) ? elapsed : elapsed + 1'b1;
    assign gt_rise = t > thr.rise_ticks;
    assign gt_min  = t > thr.min_lower_ticks;
    assign gt_max  = t > thr.max_lower_ticks;
    assign gt_vent = t > thr.vent_ticks;

    // Next location
    always_comb begin
        loc_nxt = ple_pkg::LOC_UNKNOWN;
        clr     = 1'b0;
        case (location)
            ple_pkg::LOC_GOING_UP: begin
                case (applied_drive)
                    ple_pkg::DRV_UP:   loc_nxt = gt_rise ? ple_pkg::LOC_UP
                                                         : ple_pkg::LOC_GOING_UP;
                    ple_pkg::DRV_DOWN: loc_nxt = ple_pkg::LOC_GOING_DOWN;
                    default:           loc_nxt = ple_pkg::LOC_UNKNOWN;
                endcase
            end
            ple_pkg::LOC_UP: begin
                case (applied_drive)
                    ple_pkg::DRV_UP:   loc_nxt = ple_pkg::LOC_UP;
                    ple_pkg::DRV_DOWN: loc_nxt = ple_pkg::LOC_GOING_DOWN;
                    default:           loc_nxt = ple_pkg::LOC_UNKNOWN;
                endcase
            end
            ple_pkg::LOC_GOING_DOWN: begin
                case (applied_drive)
                    ple_pkg::DRV_DOWN: loc_nxt = (gt_max || (gt_min && down_sensor))
                                                 ? ple_pkg::LOC_DOWN_VENT
                                                 : ple_pkg::LOC_GOING_DOWN;
                    ple_pkg::DRV_UP:   loc_nxt = ple_pkg::LOC_GOING_UP;
                    default:           loc_nxt = ple_pkg::LOC_UNKNOWN;
                endcase
            end
            ple_pkg::LOC_DOWN_VENT: begin
                case (applied_drive)
                    ple_pkg::DRV_UP:   loc_nxt = ple_pkg::LOC_GOING_UP;
                    ple_pkg::DRV_DOWN: begin
                        loc_nxt = ple_pkg::LOC_DOWN_VENT;
                        clr     = 1'b1;
                    end
                    default:           loc_nxt = gt_vent ? ple_pkg::LOC_DOWN_IDLE
                                                         : ple_pkg::LOC_DOWN_VENT;
                endcase
            end
            ple_pkg::LOC_DOWN_IDLE: begin
                case (applied_drive)
                    ple_pkg::DRV_UP:   loc_nxt = ple_pkg::LOC_GOING_UP;
                    ple_pkg::DRV_DOWN: loc_nxt = ple_pkg::LOC_DOWN_VENT;
                    default:           loc_nxt = ple_pkg::LOC_DOWN_IDLE;
                endcase
            end
            // unknown, and the unused codes
            default: begin
                case (applied_drive)
                    ple_pkg::DRV_UP:   loc_nxt = ple_pkg::LOC_GOING_UP;
                    ple_pkg::DRV_DOWN: loc_nxt = ple_pkg::LOC_GOING_DOWN;
                    default:           loc_nxt = ple_pkg::LOC_UNKNOWN;
                endcase
            end
        endcase
    end

    // Status of the new location
    always_comb begin
        case (loc_nxt)
            ple_pkg::LOC_GOING_UP,
            ple_pkg::LOC_UP:        st = ple_pkg::ST_SHOOTING;
            ple_pkg::LOC_DOWN_IDLE: st = ple_pkg::ST_IDLE;
            default:                st = ple_pkg::ST_RECOVERY;
        endcase
    end

    // Assemble result and new state
    always_comb begin
        res.location   = loc_nxt;
        res.elapsed    = (clr || (loc_nxt != location)) ? '0 : t;
        res.status     = st;
        res.ready_flag = (goal == ple_pkg::GOAL_ANY) || (st == ple_pkg::ST_IDLE);
        case (loc_nxt)
            ple_pkg::LOC_GOING_UP:  res.next_drive = ple_pkg::DRV_UP;
            ple_pkg::LOC_DOWN_VENT: res.next_drive = ple_pkg::DRV_VENT;
            ple_pkg::LOC_DOWN_IDLE: res.next_drive = (goal == ple_pkg::GOAL_START)
                                                     ? ple_pkg::DRV_UP : ple_pkg::DRV_VENT;
            default:                res.next_drive = ple_pkg::DRV_DOWN;
        endcase
    end

endmodule

[rtl/core/ple_checker.sv]
// Port-level checks for the position estimator, bound to the top level.
`timescale 1ns / 1ps

module ple_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_location,
    input logic [1:0] m_status,
    input logic       m_ready_flag,
    input logic [1:0] m_next_drive
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_location) && $stable(m_status)
                                && $stable(m_next_drive) && $stable(m_ready_flag))
        else $error("result beat changed while stalled");

    // Nothing is shown straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Idle location shows idle status, and is always ready
    a_idle_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_location == ple_pkg::LOC_DOWN_IDLE |->
            m_status == ple_pkg::ST_IDLE && m_ready_flag)
        else $error("down idle without idle status");

    // Moving up means shooting and driving up
    a_going_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_location == ple_pkg::LOC_GOING_UP |->
            m_status == ple_pkg::ST_SHOOTING && m_next_drive == ple_pkg::DRV_UP)
        else $error("going up with wrong status or drive");

endmodule

bind pneumatic_launcher_position_estimator ple_checker u_ple_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_location   (m_location),
    .m_status     (m_status),
    .m_ready_flag (m_ready_flag),
    .m_next_drive (m_next_drive)
);
